FILE: sv/volume_trend_ema_oscillator_assert.svh
// ----------------------------------------------------------------------------
// Volume trend EMA oscillator assertion macros
// Clocked checks on clk, held off while rst_n is low. Defining ASSERT_OFF
// leaves every check out.
// ----------------------------------------------------------------------------
`ifndef VOLUME_TREND_EMA_OSCILLATOR_ASSERT_SVH
`define VOLUME_TREND_EMA_OSCILLATOR_ASSERT_SVH
`ifndef ASSERT_OFF
// condition holds at every clock edge out of reset
`define VTEO_ASSERT(label, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
        else $error(msg);
// consequent holds in the cycle after the antecedent
`define VTEO_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define VTEO_ASSERT(label, expr, msg)
`define VTEO_ASSERT_NEXT(label, ante, cons, msg)
`endif
`endif

FILE: sv/vteo_pkg.sv
// ----------------------------------------------------------------------------
// Volume trend EMA oscillator package
// Widths, register indexes, EMA select codes and the controller to
// datapath command and status words.
// ----------------------------------------------------------------------------
package vteo_pkg;

    // fixed-point format
    localparam int FRAC_BITS   = 16;
    localparam int PRICE_W     = 32;
    localparam int VOL_W       = 32;
    localparam int SUM_W       = PRICE_W + 2;
    localparam int ACC_W       = 50;
    localparam int ALPHA_W     = 17;
    localparam int ALPHA_SHIFT = 16;

    // ema step widths
    localparam int DIFF_W = ACC_W + 1;
    localparam int HI_W   = DIFF_W - ALPHA_SHIFT;
    localparam int PH_W   = HI_W + ALPHA_W;
    localparam int PL_W   = ALPHA_SHIFT + ALPHA_W + 1;
    localparam int MAG_W  = VOL_W + FRAC_BITS;
    localparam int SV_W   = ((MAG_W > ACC_W) ? MAG_W : ACC_W) + 1;

    localparam logic [ALPHA_W-1:0] ALPHA_ONE  = ALPHA_W'(1) << ALPHA_SHIFT;
    localparam logic [PL_W-1:0]    ALPHA_HALF = PL_W'(1) << (ALPHA_SHIFT - 1);
    localparam logic [ACC_W-1:0]   ACC_MAX    = {1'b0, {(ACC_W-1){1'b1}}};
    localparam logic [ACC_W-1:0]   ACC_MIN    = {1'b1, {(ACC_W-1){1'b0}}};

    // configuration register map
    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] REG_ALPHA_LONG   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_ALPHA_SHORT  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_ALPHA_SIGNAL = 2'd2;

    localparam logic [ALPHA_W-1:0] ALPHA_LONG_RST   = 17'd5041;
    localparam logic [ALPHA_W-1:0] ALPHA_SHORT_RST  = 17'd13107;
    localparam logic [ALPHA_W-1:0] ALPHA_SIGNAL_RST = 17'd10082;

    // which ema the shared step unit works on
    localparam logic [1:0] SEL_LONG   = 2'd0;
    localparam logic [1:0] SEL_SHORT  = 2'd1;
    localparam logic [1:0] SEL_SIGNAL = 2'd2;

    typedef struct packed {
        logic       load_in;  // capture the input word
        logic       chk;      // record typical price of this candle
        logic       seed;     // seed the emas from the signed volume
        logic       load_sv;  // hold the signed volume for the ema steps
        logic       diff;     // step unit: difference and magnitude
        logic       mul;      // step unit: partial products
        logic       upd;      // step unit: accumulator update
        logic       sat;      // register saturated long minus short
        logic       pub;      // load the output register
        logic [1:0] sel;      // ema under work
    } cmd_t;

    typedef struct packed {
        logic start;          // captured series_start flag
    } status_t;

endpackage

FILE: sv/vteo_ctrl.sv
// ----------------------------------------------------------------------------
// Volume trend EMA oscillator controller
// Sequences one candle: price check, then (not for a series' first candle)
// seeding or three ema steps on the shared step unit, then the output register.
// ----------------------------------------------------------------------------
`include "volume_trend_ema_oscillator_assert.svh"

module vteo_ctrl
    import vteo_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    in_valid,
    output logic    in_ready,
    output logic    out_valid,
    input  logic    out_ready,
    input  status_t status,
    output cmd_t    cmd
);

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_CHK  = 3'd1;
    localparam logic [2:0] ST_DIFF = 3'd2;
    localparam logic [2:0] ST_MUL  = 3'd3;
    localparam logic [2:0] ST_UPD  = 3'd4;
    localparam logic [2:0] ST_SAT  = 3'd5;
    localparam logic [2:0] ST_PUB  = 3'd6;

    localparam logic [1:0] PH_NONE = 2'd0;
    localparam logic [1:0] PH_ONE  = 2'd1;
    localparam logic [1:0] PH_RUN  = 2'd2;

    logic [2:0] state_reg, state_next;
    logic [1:0] phase_reg, phase_next;
    logic [1:0] sel_reg, sel_next;
    logic       out_valid_reg, out_valid_next;
    logic       pub_ok;

    // output slot free or emptied this cycle
    assign pub_ok = !out_valid_reg || out_ready;

    // next state and commands
    always_comb
    begin
        state_next = state_reg;
        phase_next = phase_reg;
        sel_next   = sel_reg;
        cmd        = '0;
        cmd.sel    = sel_reg;
        in_ready   = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.load_in = 1'b1;
                    state_next  = ST_CHK;
                end
            end
            ST_CHK:
            begin
                cmd.chk = 1'b1;
                if (status.start || phase_reg == PH_NONE)
                begin
                    phase_next = PH_ONE;
                    state_next = ST_IDLE;
                end
                else if (phase_reg == PH_ONE)
                begin
                    cmd.seed   = 1'b1;
                    phase_next = PH_RUN;
                    state_next = ST_PUB;
                end
                else
                begin
                    cmd.load_sv = 1'b1;
                    phase_next  = PH_RUN;
                    sel_next    = SEL_LONG;
                    state_next  = ST_DIFF;
                end
            end
            ST_DIFF:
            begin
                cmd.diff   = 1'b1;
                state_next = ST_MUL;
            end
            ST_MUL:
            begin
                cmd.mul    = 1'b1;
                state_next = ST_UPD;
            end
            ST_UPD:
            begin
                cmd.upd = 1'b1;
                case (sel_reg)
                    SEL_LONG:
                    begin
                        sel_next   = SEL_SHORT;
                        state_next = ST_DIFF;
                    end
                    SEL_SHORT:  state_next = ST_SAT;
                    default:    state_next = ST_PUB;
                endcase
            end
            ST_SAT:
            begin
                cmd.sat    = 1'b1;
                sel_next   = SEL_SIGNAL;
                state_next = ST_DIFF;
            end
            ST_PUB:
            begin
                if (pub_ok)
                begin
                    cmd.pub    = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:    state_next = ST_IDLE;
        endcase
    end

    // output word valid flag
    always_comb
    begin
        if (cmd.pub)
            out_valid_next = 1'b1;
        else if (out_ready)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            phase_reg     <= PH_NONE;
            sel_reg       <= SEL_LONG;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            phase_reg     <= phase_next;
            sel_reg       <= sel_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_valid = out_valid_reg;

    // checks
    `VTEO_ASSERT_NEXT(a_accept_to_chk, in_valid && in_ready, state_reg == ST_CHK,
        "accepted word did not move to the price check")
    `VTEO_ASSERT_NEXT(a_signal_then_pub, state_reg == ST_UPD && sel_reg == SEL_SIGNAL,
        state_reg == ST_PUB, "signal ema update not followed by publish")
    `VTEO_ASSERT_NEXT(a_pub_waits, state_reg == ST_PUB && out_valid_reg && !out_ready,
        state_reg == ST_PUB && out_valid_reg, "pending output word overwritten")

endmodule

FILE: sv/vteo_dp.sv
// ----------------------------------------------------------------------------
// Volume trend EMA oscillator datapath
// Input capture, typical price compare, signed volume, the three ema
// accumulators, one shared ema step unit and the output register.
// ----------------------------------------------------------------------------
`include "volume_trend_ema_oscillator_assert.svh"

module vteo_dp
    import vteo_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  cmd_t                 cmd,
    output status_t              status,
    input  logic [PRICE_W-1:0]   price_lo,
    input  logic [PRICE_W-1:0]   price_hi,
    input  logic [PRICE_W-1:0]   price_cl,
    input  logic [VOL_W-1:0]     trade_volume,
    input  logic                 series_start,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [ALPHA_W-1:0]   cfg_data,
    output logic [ACC_W-1:0]     signal_line
);

    // captured input word
    logic [PRICE_W-1:0] lo_reg, hi_reg, cl_reg;
    logic [VOL_W-1:0]   vol_reg;
    logic               start_reg;

    // configuration
    logic [ALPHA_W-1:0] alpha_long_reg, alpha_short_reg, alpha_signal_reg;

    // series state
    logic [SUM_W-1:0]  prev_sum_reg;
    logic [ACC_W-1:0]  long_acc_reg, short_acc_reg, sig_acc_reg;
    logic [ACC_W-1:0]  sv_reg, satdiff_reg, signal_line_reg;

    // step unit registers
    logic              neg_reg;
    logic [DIFF_W-1:0] m_reg;
    logic [ALPHA_W-1:0] a_reg;
    logic [PH_W-1:0]   prod_hi_reg;
    logic [PL_W-1:0]   prod_lo_reg;

    // combinational
    logic [SUM_W-1:0]   sum_c;
    logic               up_c;
    logic [SV_W-1:0]    mag_c;
    logic [ACC_W-1:0]   sv_c;
    logic [DIFF_W-1:0]  ls_diff_c;
    logic [ACC_W-1:0]   satdiff_c;
    logic [ACC_W-1:0]   x_c, acc_c;
    logic [ALPHA_W-1:0] alpha_c, a_c;
    logic [DIFF_W-1:0]  d_c, m_c;
    logic [PH_W-1:0]    prod_hi_c;
    logic [PL_W-1:0]    prod_lo_c;
    logic [PH_W-1:0]    q_c, acc_ext_c, res_c;
    logic [ACC_W-1:0]   acc_new_c;

    assign status.start = start_reg;

    // typical price and trend
    assign sum_c = SUM_W'(lo_reg) + SUM_W'(hi_reg) + SUM_W'(cl_reg);
    assign up_c  = sum_c > prev_sum_reg;

    // signed scaled volume, saturated to the accumulator range
    assign mag_c = SV_W'(vol_reg) << FRAC_BITS;
    always_comb
    begin
        if (up_c)
            sv_c = (mag_c > SV_W'(ACC_MAX)) ? ACC_MAX : ACC_W'(mag_c);
        else
            sv_c = (mag_c > SV_W'(ACC_MAX) + SV_W'(1)) ? ACC_MIN : ACC_W'(-mag_c);
    end

    // saturated long minus short
    assign ls_diff_c = {long_acc_reg[ACC_W-1], long_acc_reg}
                     - {short_acc_reg[ACC_W-1], short_acc_reg};
    always_comb
    begin
        if (ls_diff_c[DIFF_W-1] != ls_diff_c[ACC_W-1])
            satdiff_c = ls_diff_c[DIFF_W-1] ? ACC_MIN : ACC_MAX;
        else
            satdiff_c = ls_diff_c[ACC_W-1:0];
    end

    // operand select for the step unit
    always_comb
    begin
        case (cmd.sel)
            SEL_LONG:
            begin
                x_c     = sv_reg;
                acc_c   = long_acc_reg;
                alpha_c = alpha_long_reg;
            end
            SEL_SHORT:
            begin
                x_c     = sv_reg;
                acc_c   = short_acc_reg;
                alpha_c = alpha_short_reg;
            end
            default:
            begin
                x_c     = satdiff_reg;
                acc_c   = sig_acc_reg;
                alpha_c = alpha_signal_reg;
            end
        endcase
    end

    // step 1: difference, magnitude, clamped factor
    assign d_c = {x_c[ACC_W-1], x_c} - {acc_c[ACC_W-1], acc_c};
    assign m_c = d_c[DIFF_W-1] ? -d_c : d_c;
    assign a_c = (alpha_c > ALPHA_ONE) ? ALPHA_ONE : alpha_c;

    // step 2: split product, low half rounded half up
    assign prod_hi_c = m_reg[DIFF_W-1:ALPHA_SHIFT] * a_reg;
    assign prod_lo_c = m_reg[ALPHA_SHIFT-1:0] * a_reg + ALPHA_HALF;

    // step 3: move accumulator toward the input
    assign q_c       = prod_hi_reg + PH_W'(prod_lo_reg >> ALPHA_SHIFT);
    assign acc_ext_c = {{(PH_W-ACC_W){acc_c[ACC_W-1]}}, acc_c};
    assign res_c     = neg_reg ? acc_ext_c - q_c : acc_ext_c + q_c;
    assign acc_new_c = res_c[ACC_W-1:0];

    // input word and step unit payload
    always_ff @(posedge clk)
    begin
        if (cmd.load_in)
        begin
            lo_reg    <= price_lo;
            hi_reg    <= price_hi;
            cl_reg    <= price_cl;
            vol_reg   <= trade_volume;
            start_reg <= series_start;
        end
        if (cmd.load_sv)
            sv_reg <= sv_c;
        if (cmd.sat)
            satdiff_reg <= satdiff_c;
        if (cmd.diff)
        begin
            neg_reg <= d_c[DIFF_W-1];
            m_reg   <= m_c;
            a_reg   <= a_c;
        end
        if (cmd.mul)
        begin
            prod_hi_reg <= prod_hi_c;
            prod_lo_reg <= prod_lo_c;
        end
        if (cmd.pub)
            signal_line_reg <= sig_acc_reg;
    end

    // configuration and series state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            alpha_long_reg   <= ALPHA_LONG_RST;
            alpha_short_reg  <= ALPHA_SHORT_RST;
            alpha_signal_reg <= ALPHA_SIGNAL_RST;
            prev_sum_reg     <= '0;
            long_acc_reg     <= '0;
            short_acc_reg    <= '0;
            sig_acc_reg      <= '0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    REG_ALPHA_LONG:   alpha_long_reg   <= cfg_data;
                    REG_ALPHA_SHORT:  alpha_short_reg  <= cfg_data;
                    REG_ALPHA_SIGNAL: alpha_signal_reg <= cfg_data;
                    default:          ;
                endcase
            end
            if (cmd.chk)
                prev_sum_reg <= sum_c;
            if (cmd.seed)
            begin
                long_acc_reg  <= sv_c;
                short_acc_reg <= sv_c;
                sig_acc_reg   <= '0;
            end
            if (cmd.upd)
            begin
                case (cmd.sel)
                    SEL_LONG:   long_acc_reg  <= acc_new_c;
                    SEL_SHORT:  short_acc_reg <= acc_new_c;
                    SEL_SIGNAL: sig_acc_reg   <= acc_new_c;
                    default:    ;
                endcase
            end
        end
    end

    assign signal_line = signal_line_reg;

    // checks
    `VTEO_ASSERT(a_step_bounded, !cmd.upd || q_c <= PH_W'(m_reg),
        "ema step larger than the distance to the input")
    `VTEO_ASSERT_NEXT(a_seed_signal_zero, cmd.seed, sig_acc_reg == '0,
        "signal ema not cleared by the seeding candle")
    `VTEO_ASSERT_NEXT(a_seed_equal, cmd.seed, long_acc_reg == short_acc_reg,
        "long and short ema differ after seeding")

endmodule

FILE: sv/volume_trend_ema_oscillator.sv
// ----------------------------------------------------------------------------
// Volume trend EMA oscillator
// Signed-volume long and short EMAs and a signal EMA of their difference,
// one candle per input word, one signal word per candle after the first.
// ----------------------------------------------------------------------------
// Per candle: the first of a series only records its price, no output; a
// seeding candle seeds the EMAs and loads the output. Running candles are
// taken one at a time, set by the single shared EMA step unit (difference,
// multiply, update per EMA, three EMAs in turn plus price check, difference
// saturation and output load). Output register frees the input.
// Reset: asynchronous, clears all EMAs, the previous price and the series
// phase, and loads the default factors for N = 25, 9 and 12.
module volume_trend_ema_oscillator
    import vteo_pkg::*;
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    in_valid,
    output logic                    in_ready,
    input  logic [PRICE_W-1:0]      price_lo,
    input  logic [PRICE_W-1:0]      price_hi,
    input  logic [PRICE_W-1:0]      price_cl,
    input  logic [VOL_W-1:0]        trade_volume,
    input  logic                    series_start,
    output logic                    out_valid,
    input  logic                    out_ready,
    output logic signed [ACC_W-1:0] signal_line,
    input  logic                    cfg_valid,
    output logic                    cfg_ready,
    input  logic [CFG_IDX_W-1:0]    cfg_index,
    input  logic [ALPHA_W-1:0]      cfg_data
);

    cmd_t             cmd;
    status_t          status;
    logic [ACC_W-1:0] signal_word;

    // register writes are always accepted
    assign cfg_ready = 1'b1;

    vteo_ctrl u_ctrl
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .status    (status),
        .cmd       (cmd)
    );

    vteo_dp u_dp
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .status       (status),
        .price_lo     (price_lo),
        .price_hi     (price_hi),
        .price_cl     (price_cl),
        .trade_volume (trade_volume),
        .series_start (series_start),
        .cfg_we       (cfg_valid && cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .signal_line  (signal_word)
    );

    assign signal_line = $signed(signal_word);

endmodule
